// ===== sv/pcs_pkg.sv =====
// Shared types, constants and codes for the playlist cursor sequencer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pcs_pkg;

  localparam int PCS_MAX_ENTRIES = 1024;
  localparam int PCS_OP_W        = 3;
  localparam int PCS_IDX_W       = 10;
  localparam int PCS_CNT_W       = 11;
  localparam int PCS_DRAW_W      = 64;
  localparam int PCS_HALF_W      = PCS_DRAW_W / 2;
  localparam int PCS_CFG_IDX_W   = 1;
  localparam int PCS_CFG_DATA_W  = 64;

  localparam logic [PCS_DRAW_W-1:0] PCS_SEED_RESET = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [PCS_DRAW_W-1:0] PCS_MIX_MULT   = 64'h2545_F491_4F6C_DD1D;
  localparam int PCS_XS_A = 12;
  localparam int PCS_XS_B = 25;
  localparam int PCS_XS_C = 27;

  typedef enum logic [PCS_OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_SET    = 3'd3,
    OP_NEXT   = 3'd4,
    OP_PREV   = 3'd5,
    OP_PEEK   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MODE_SEQ  = 2'd0,
    MODE_LOOP = 2'd1,
    MODE_SHUF = 2'd2
  } mode_t;

  typedef enum logic [PCS_CFG_IDX_W-1:0] {
    CFG_PLAY_MODE    = 1'd0,
    CFG_SHUFFLE_SEED = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [PCS_OP_W-1:0]  op;
    logic [PCS_IDX_W-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [PCS_IDX_W-1:0] item_index;
    logic                 item_valid;
    logic                 accepted;
    logic [PCS_CNT_W-1:0] count_now;
    logic                 cursor_set;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_MOD,
    ST_COMMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;
    logic load_rng;
    logic step;
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic mod_start;
    logic take_pick;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_draw;
    logic mod_done;
    logic pick_eq;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/playlist_cursor_sequencer.sv =====
// Top level of the playlist cursor sequencer: controller plus datapath.
// Depends on pcs_pkg, pcs_ctrl, pcs_dp and pcs_modu.
//
//   channel  ports                                  payload
//   input    in_valid / in_ready / in_data          op, entry_index
//   result   out_valid / out_ready / out_data       item, flags, count
//   config   cfg_wr_en / cfg_index / cfg_wdata      play_mode, shuffle_seed
//
// One item at a time. Add, remove, clear, set_current and non-shuffle moves
// register their result in the COMMIT state that follows EXEC; the next input
// transfer is taken once the controller is back in IDLE.
// A shuffle move or peek runs STEP, MUL_A to MUL_D and MOD once per draw;
// each draw is bound by the bit-serial remainder unit.
// Synchronous active-low reset; no clearing pass. A new item is taken while
// a result waits; the commit of the next result stalls until it is taken.

`default_nettype none

module playlist_cursor_sequencer #(
  parameter int MAX_ENTRIES = pcs_pkg::PCS_MAX_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire pcs_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output pcs_pkg::out_t                          out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pcs_pkg::PCS_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pcs_pkg::PCS_CFG_DATA_W-1:0] cfg_wdata
);
  import pcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcs_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/pcs_modu.sv =====
// Bit-serial remainder unit: 64-bit dividend modulo a narrow divisor.
// Depends on pcs_pkg for the dividend width.
`default_nettype none

module pcs_modu #(
  parameter int DIV_W = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pcs_pkg::PCS_DRAW_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]              divisor,
  output logic                               done,
  output logic [DIV_W-1:0]                   rem
);
  import pcs_pkg::*;

  localparam int STEP_W = $clog2(PCS_DRAW_W);

  logic [PCS_DRAW_W-1:0] num_r;
  logic [DIV_W-1:0]      rem_r;
  logic [STEP_W-1:0]     cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic [DIV_W-1:0] rem_nxt;

  // One quotient bit per cycle, most significant dividend bit first.
  assign trial   = {rem_r, num_r[PCS_DRAW_W-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign diff    = trial - {1'b0, divisor};
  assign rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == STEP_W'(PCS_DRAW_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[PCS_DRAW_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== sv/pcs_dp.sv =====
// Datapath: entry count, cursor, generator, multiplier, result register.
// Depends on pcs_pkg and instantiates pcs_modu.
`default_nettype none

module pcs_dp #(
  parameter int MAX_ENTRIES = pcs_pkg::PCS_MAX_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pcs_pkg::in_t                      in_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pcs_pkg::PCS_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pcs_pkg::PCS_CFG_DATA_W-1:0] cfg_wdata,
  input  wire pcs_pkg::cmd_t                     cmd,
  output pcs_pkg::sts_t                          sts,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output pcs_pkg::out_t                          out_data
);
  import pcs_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > PCS_IDX_W) ? CW : PCS_IDX_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [PCS_HALF_W-1:0] MULT_LO = PCS_MIX_MULT[PCS_HALF_W-1:0];
  localparam logic [PCS_HALF_W-1:0] MULT_HI = PCS_MIX_MULT[PCS_DRAW_W-1:PCS_HALF_W];

  function automatic logic [PCS_DRAW_W-1:0] xorshift(input logic [PCS_DRAW_W-1:0] x);
    logic [PCS_DRAW_W-1:0] a;
    logic [PCS_DRAW_W-1:0] b;
    a = x ^ (x >> PCS_XS_A);
    b = a ^ (a << PCS_XS_B);
    return b ^ (b >> PCS_XS_C);
  endfunction

  // Architectural state.
  mode_t                 mode_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         cursor_r;
  logic                  valid_r;
  logic [PCS_DRAW_W-1:0] rng_r;

  // Working registers of one operation.
  op_t                   op_r;
  logic [PCS_IDX_W-1:0]  idx_r;
  logic [PCS_DRAW_W-1:0] nav_rng_r;
  logic [PCS_DRAW_W-1:0] mul_r;
  logic [PCS_DRAW_W-1:0] acc_r;
  logic [CW-1:0]         pick_r;

  logic                  out_valid_r;
  out_t                  out_data_r;

  logic [PCS_HALF_W-1:0] mul_a_op;
  logic [PCS_HALF_W-1:0] mul_b_op;
  logic [PCS_DRAW_W-1:0] mul_p;
  logic [PCS_DRAW_W-1:0] dividend;
  logic                  mod_done;
  logic [CW-1:0]         mod_rem;

  logic                  fwd;
  logic [CW:0]           cur_inc;
  logic [CW-1:0]         nav_cur;
  logic                  nav_valid;
  logic                  nav_ok;

  logic [XW-1:0]         idx_x;
  logic [XW-1:0]         count_x;
  logic [CW-1:0]         idx_c;
  logic [CW-1:0]         cnt_dec;
  logic [CW-1:0]         rm_cur;
  logic                  rm_valid;

  logic [CW-1:0]         count_nxt;
  logic [CW-1:0]         cursor_nxt;
  logic                  valid_nxt;
  logic [PCS_DRAW_W-1:0] rng_nxt;
  logic [CW-1:0]         item_cur;
  logic                  item_ok;
  logic                  acc_ok;
  out_t                  res;

  // Low 64 bits of the 64x64 product from three 32x32 partial products.
  assign mul_a_op = cmd.mul_c ? nav_rng_r[PCS_DRAW_W-1:PCS_HALF_W]
                              : nav_rng_r[PCS_HALF_W-1:0];
  assign mul_b_op = cmd.mul_b ? MULT_HI : MULT_LO;
  assign mul_p    = mul_a_op * mul_b_op;
  assign dividend = acc_r + {mul_r[PCS_HALF_W-1:0], {PCS_HALF_W{1'b0}}};

  pcs_modu #(
    .DIV_W (CW)
  ) u_modu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (dividend),
    .divisor  (count_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Move of the cursor for next, previous and peek.
  assign fwd     = (op_r != OP_PREV);
  assign cur_inc = {1'b0, cursor_r} + 1'b1;

  always_comb begin
    nav_cur   = cursor_r;
    nav_valid = valid_r;
    nav_ok    = 1'b0;
    if (count_r != '0) begin
      if (!valid_r) begin
        nav_cur   = '0;
        nav_valid = 1'b1;
        nav_ok    = 1'b1;
      end else begin
        case (mode_r)
          MODE_SEQ: begin
            if (fwd) begin
              if (cur_inc < {1'b0, count_r}) begin
                nav_cur = cur_inc[CW-1:0];
                nav_ok  = 1'b1;
              end
            end else begin
              if (cursor_r != '0) nav_cur = cursor_r - 1'b1;
              nav_ok = 1'b1;
            end
          end
          MODE_LOOP: begin
            if (fwd) begin
              nav_cur = (cur_inc == {1'b0, count_r}) ? '0 : cur_inc[CW-1:0];
            end else begin
              nav_cur = (cursor_r == '0) ? count_r - 1'b1 : cursor_r - 1'b1;
            end
            nav_ok = 1'b1;
          end
          default: begin
            nav_cur = (count_r == CW'(1)) ? '0 : pick_r;
            nav_ok  = 1'b1;
          end
        endcase
      end
    end
  end

  assign idx_x   = XW'(idx_r);
  assign count_x = XW'(count_r);
  assign idx_c   = CW'(idx_r);

  // Effect of a remove on the cursor.
  always_comb begin
    cnt_dec  = count_r - 1'b1;
    rm_cur   = (valid_r && idx_c < cursor_r) ? cursor_r - 1'b1 : cursor_r;
    rm_valid = valid_r && (idx_c != cursor_r);
    if (rm_valid && rm_cur >= cnt_dec) begin
      rm_cur   = cnt_dec;
      rm_valid = 1'b0;
    end
  end

  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    valid_nxt  = valid_r;
    rng_nxt    = rng_r;
    item_cur   = '0;
    item_ok    = 1'b0;
    acc_ok     = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        if (count_r < MAX_CNT) begin
          count_nxt = count_r + 1'b1;
          acc_ok    = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (idx_x < count_x) begin
          count_nxt  = cnt_dec;
          cursor_nxt = rm_cur;
          valid_nxt  = rm_valid;
          acc_ok     = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_nxt  = '0;
        cursor_nxt = '0;
        valid_nxt  = 1'b0;
        acc_ok     = 1'b1;
      end
      OP_SET: begin
        if (idx_x < count_x) begin
          cursor_nxt = idx_c;
          valid_nxt  = 1'b1;
          acc_ok     = 1'b1;
        end
      end
      OP_NEXT, OP_PREV: begin
        cursor_nxt = nav_cur;
        valid_nxt  = nav_valid;
        rng_nxt    = nav_rng_r;
        if (nav_ok) begin
          item_cur = nav_cur;
          item_ok  = 1'b1;
          acc_ok   = 1'b1;
        end
      end
      OP_PEEK: begin
        // A sequential next at the end leaves the copy at the cursor entry.
        if (nav_valid && nav_cur < count_r) begin
          item_cur = nav_cur;
          item_ok  = 1'b1;
          acc_ok   = 1'b1;
        end
      end
      default: ;
    endcase
    res.item_index = PCS_IDX_W'(item_cur);
    res.item_valid = item_ok;
    res.accepted   = acc_ok;
    res.count_now  = PCS_CNT_W'(count_nxt);
    res.cursor_set = valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SEQ;
      count_r  <= '0;
      cursor_r <= '0;
      valid_r  <= 1'b0;
      rng_r    <= PCS_SEED_RESET;
    end else begin
      if (cmd.commit) begin
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
        valid_r  <= valid_nxt;
        rng_r    <= rng_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_PLAY_MODE: begin
            if (cfg_wdata <= PCS_CFG_DATA_W'(MODE_SHUF)) mode_r <= mode_t'(cfg_wdata[1:0]);
          end
          CFG_SHUFFLE_SEED: begin
            rng_r <= (cfg_wdata == '0) ? PCS_DRAW_W'(1) : cfg_wdata;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= op_t'(in_data.op);
      idx_r <= in_data.entry_index;
    end
    if (cmd.load_rng) nav_rng_r <= rng_r;
    else if (cmd.step) nav_rng_r <= xorshift(nav_rng_r);
    if (cmd.mul_a || cmd.mul_b || cmd.mul_c) mul_r <= mul_p;
    if (cmd.mul_b) acc_r <= mul_r;
    else if (cmd.mul_c) acc_r <= dividend;
    if (cmd.take_pick) pick_r <= mod_rem;
    if (cmd.commit) out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.need_draw = (op_r == OP_NEXT || op_r == OP_PREV || op_r == OP_PEEK) &&
                         (count_r > CW'(1)) && valid_r && (mode_r == MODE_SHUF);
  assign sts.mod_done  = mod_done;
  assign sts.pick_eq   = (mod_rem == cursor_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/pcs_ctrl.sv =====
// Controller state machine: sequences latch, shuffle draws and commit.
// Depends on pcs_pkg for the state, command and status types.
`default_nettype none

module pcs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pcs_pkg::sts_t sts,
  output pcs_pkg::cmd_t      cmd
);
  import pcs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.load_rng = 1'b1;
        state_nxt    = sts.need_draw ? ST_STEP : ST_COMMIT;
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mod_start = 1'b1;
        state_nxt     = ST_MOD;
      end
      ST_MOD: begin
        // A draw equal to the cursor is thrown away and drawn again.
        if (sts.mod_done) begin
          cmd.take_pick = 1'b1;
          state_nxt     = sts.pick_eq ? ST_STEP : ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the playlist cursor sequencer: directed table, loop-mode and
// shuffle passes, random phases; checked by a cursor/xorshift64* predictor in this file.
// Depends on pcs_pkg and playlist_cursor_sequencer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  localparam logic [PCS_OP_W-1:0] OP_UNUSED   = 3'd7;
  localparam logic [1:0]          MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 45;
  localparam int LOOP_FILL   = 48;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_wr_en;
  logic [PCS_CFG_IDX_W-1:0]  cfg_index;
  logic [PCS_CFG_DATA_W-1:0] cfg_wdata;

  out_t     pending_results[$];
  dir_row_t directed_rows[$];
  int       err_count = 0;
  int       results_seen = 0;
  bit       idle_on = 1'b1;

  // Predicted block state.
  logic [1:0]           m_mode;
  logic [PCS_CNT_W-1:0] m_count;
  logic [PCS_CNT_W-1:0] m_cursor;
  bit                   m_cur_ok;
  logic [63:0]          m_rng;

  // Scratch copy that next, previous and peek work on.
  logic [PCS_CNT_W-1:0] nav_cur;
  bit                   nav_ok;
  logic [63:0]          nav_rng;

  playlist_cursor_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [63:0] xs_next();
    nav_rng = nav_rng ^ (nav_rng >> PCS_XS_A);
    nav_rng = nav_rng ^ (nav_rng << PCS_XS_B);
    nav_rng = nav_rng ^ (nav_rng >> PCS_XS_C);
    return nav_rng * PCS_MIX_MULT;
  endfunction

  // Moves the scratch cursor; returns 1 when an entry comes out.
  function automatic bit nav_step(bit forward);
    logic [PCS_CNT_W-1:0] pick;
    if (m_count == 0) return 1'b0;
    if (!nav_ok) begin
      nav_cur = '0;
      nav_ok  = 1'b1;
      return 1'b1;
    end
    case (m_mode)
      MODE_SEQ: begin
        if (forward) begin
          if (nav_cur + 1 >= m_count) return 1'b0;
          nav_cur = nav_cur + 1'b1;
        end else if (nav_cur > 0) begin
          nav_cur = nav_cur - 1'b1;
        end
      end
      MODE_LOOP: begin
        if (forward) nav_cur = PCS_CNT_W'((nav_cur + 1) % m_count);
        else nav_cur = PCS_CNT_W'((nav_cur + m_count - 1) % m_count);
      end
      default: begin
        if (m_count == 1) begin
          nav_cur = '0;
        end else begin
          pick = PCS_CNT_W'(xs_next() % m_count);
          while (pick == nav_cur) pick = PCS_CNT_W'(xs_next() % m_count);
          nav_cur = pick;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic out_t step_playlist(in_t it);
    out_t r;
    r = '0;
    nav_cur = m_cursor;
    nav_ok  = m_cur_ok;
    nav_rng = m_rng;
    case (it.op)
      OP_ADD: begin
        if (m_count < PCS_MAX_ENTRIES) begin
          m_count = m_count + 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (it.entry_index < m_count) begin
          m_count = m_count - 1'b1;
          if (m_cur_ok && it.entry_index < m_cursor) m_cursor = m_cursor - 1'b1;
          else if (m_cur_ok && it.entry_index == m_cursor) m_cur_ok = 1'b0;
          if (m_cur_ok && m_cursor >= m_count) begin
            m_cursor = m_count;
            m_cur_ok = 1'b0;
          end
          r.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        m_count  = '0;
        m_cursor = '0;
        m_cur_ok = 1'b0;
        r.accepted = 1'b1;
      end
      OP_SET: begin
        if (it.entry_index < m_count) begin
          m_cursor = PCS_CNT_W'(it.entry_index);
          m_cur_ok = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_NEXT, OP_PREV: begin
        if (nav_step(it.op == OP_NEXT)) begin
          r.item_index = nav_cur[PCS_IDX_W-1:0];
          r.item_valid = 1'b1;
          r.accepted   = 1'b1;
        end
        m_cursor = nav_cur;
        m_cur_ok = nav_ok;
        m_rng    = nav_rng;
      end
      OP_PEEK: begin
        void'(nav_step(1'b1));
        // Past the end in sequential mode the peek still reports the cursor entry.
        if (nav_ok && nav_cur < m_count) begin
          r.item_index = nav_cur[PCS_IDX_W-1:0];
          r.item_valid = 1'b1;
          r.accepted   = 1'b1;
        end
      end
      default: ;
    endcase
    r.count_now  = m_count;
    r.cursor_set = m_cur_ok;
    return r;
  endfunction

  function automatic in_t cmd(logic [PCS_OP_W-1:0] op, logic [PCS_IDX_W-1:0] idx);
    in_t it;
    it.op = op;
    it.entry_index = idx;
    return it;
  endfunction

  function automatic out_t res(logic [PCS_IDX_W-1:0] item, bit iv, bit acc,
                               logic [PCS_CNT_W-1:0] cnt, bit cs);
    out_t r;
    r.item_index = item;
    r.item_valid = iv;
    r.accepted   = acc;
    r.count_now  = cnt;
    r.cursor_set = cs;
    return r;
  endfunction

  function automatic void add_row(logic [PCS_OP_W-1:0] op, logic [PCS_IDX_W-1:0] idx,
                                  bit typed, out_t want);
    dir_row_t row;
    row.stim  = cmd(op, idx);
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Mostly in-range indices so that removes and cursor moves reach deep states.
  function automatic in_t random_item();
    in_t it;
    int unsigned r;
    logic [PCS_IDX_W-1:0] in_range;
    r = $urandom_range(0, 99);
    it.entry_index = PCS_IDX_W'($urandom);
    in_range = (m_count == 0) ? '0 : PCS_IDX_W'($urandom_range(0, m_count - 1));
    if (r < 18) it.op = OP_ADD;
    else if (r < 30) begin
      it.op = OP_REMOVE;
      it.entry_index = in_range;
    end else if (r < 34) it.op = OP_REMOVE;
    else if (r < 46) begin
      it.op = OP_SET;
      it.entry_index = in_range;
    end else if (r < 50) it.op = OP_SET;
    else if (r < 68) it.op = OP_NEXT;
    else if (r < 80) it.op = OP_PREV;
    else if (r < 93) it.op = OP_PEEK;
    else if (r < 96) it.op = OP_CLEAR;
    else it.op = OP_UNUSED;
    return it;
  endfunction

  task automatic offer(in_t it, bit typed, out_t want);
    int unsigned gap;
    out_t predicted;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = step_playlist(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic go(in_t it);
    offer(it, 1'b0, '0);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t r, logic [63:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    if (r == CFG_PLAY_MODE) begin
      if (v <= MODE_SHUF) m_mode = v[1:0];
    end else begin
      m_rng = (v == 0) ? 64'd1 : v;
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result sink: random stalls per transfer, plus long holds so the block backs up.
  initial begin : result_sink
    int unsigned wait_n;
    int sink_xfers;
    sink_xfers = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_xfers == 60 || sink_xfers == 400) wait_n = HOLD_CYCLES;
      else wait_n = idle_on ? $urandom_range(0, 3) : 0;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_ready)) @(posedge clk);
      sink_xfers++;
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    string diffs;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: %h", out_data));
      end else begin
        want = pending_results.pop_front();
        diffs = "";
        if (out_data.item_index !== want.item_index) diffs = {diffs, " item_index"};
        if (out_data.item_valid !== want.item_valid) diffs = {diffs, " item_valid"};
        if (out_data.accepted !== want.accepted) diffs = {diffs, " accepted"};
        if (out_data.count_now !== want.count_now) diffs = {diffs, " count_now"};
        if (out_data.cursor_set !== want.cursor_set) diffs = {diffs, " cursor_set"};
        if (diffs != "")
          flag_mismatch($sformatf("result %0d bad%s: got %h want %h",
                                  results_seen, diffs, out_data, want));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    int p;
    logic [1:0] mode_pick;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_PLAY_MODE;
    cfg_wdata = '0;
    m_mode    = MODE_SEQ;
    m_count   = '0;
    m_cursor  = '0;
    m_cur_ok  = 1'b0;
    m_rng     = PCS_SEED_RESET;

    // Sequential mode after reset: empty list, unused op, ends of the list, removes.
    add_row(OP_NEXT,   10'd0,    1, res(0, 0, 0, 0, 0));
    add_row(OP_PREV,   10'd1023, 1, res(0, 0, 0, 0, 0));
    add_row(OP_PEEK,   10'd0,    1, res(0, 0, 0, 0, 0));
    add_row(OP_REMOVE, 10'd0,    1, res(0, 0, 0, 0, 0));
    add_row(OP_SET,    10'd1023, 1, res(0, 0, 0, 0, 0));
    add_row(OP_UNUSED, 10'd1023, 1, res(0, 0, 0, 0, 0));
    add_row(OP_ADD,    10'd0,    1, res(0, 0, 1, 1, 0));
    add_row(OP_ADD,    10'd682,  1, res(0, 0, 1, 2, 0));
    add_row(OP_ADD,    10'd341,  1, res(0, 0, 1, 3, 0));
    add_row(OP_PEEK,   10'd0,    1, res(0, 1, 1, 3, 0));
    add_row(OP_NEXT,   10'd0,    1, res(0, 1, 1, 3, 1));
    add_row(OP_PREV,   10'd0,    1, res(0, 1, 1, 3, 1));
    add_row(OP_SET,    10'd2,    1, res(0, 0, 1, 3, 1));
    add_row(OP_NEXT,   10'd0,    1, res(0, 0, 0, 3, 1));
    add_row(OP_PEEK,   10'd0,    1, res(2, 1, 1, 3, 1));
    add_row(OP_PREV,   10'd0,    0, '0);
    add_row(OP_SET,    10'd3,    1, res(0, 0, 0, 3, 1));
    add_row(OP_REMOVE, 10'd0,    0, '0);
    add_row(OP_REMOVE, 10'd0,    1, res(0, 0, 1, 1, 0));
    add_row(OP_NEXT,   10'd0,    0, '0);
    add_row(OP_REMOVE, 10'd0,    0, '0);
    add_row(OP_ADD,    10'd0,    0, '0);
    add_row(OP_ADD,    10'd0,    0, '0);
    add_row(OP_CLEAR,  10'd0,    1, res(0, 0, 1, 0, 0));
    add_row(OP_NEXT,   10'd0,    1, res(0, 0, 0, 0, 0));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    settle();

    // Loop mode with back-to-back transfers: wrap at both ends of the list.
    cfg_write(CFG_PLAY_MODE, 64'(MODE_LOOP));
    idle_on = 1'b0;
    while (m_count < LOOP_FILL) go(cmd(OP_ADD, 10'd0));
    go(cmd(OP_SET, PCS_IDX_W'(LOOP_FILL - 1)));
    go(cmd(OP_NEXT, 10'd0));
    go(cmd(OP_PREV, 10'd0));
    go(cmd(OP_PEEK, 10'd0));
    go(cmd(OP_REMOVE, PCS_IDX_W'(LOOP_FILL - 1)));
    go(cmd(OP_ADD, 10'd0));
    go(cmd(OP_SET, PCS_IDX_W'(LOOP_FILL - 1)));
    go(cmd(OP_REMOVE, 10'd0));
    go(cmd(OP_NEXT, 10'd0));
    settle();

    // Shuffle over the loaded list, then down to a single entry; a zero seed loads as one.
    idle_on = 1'b1;
    cfg_write(CFG_PLAY_MODE, 64'(MODE_SHUF));
    cfg_write(CFG_SHUFFLE_SEED, 64'd0);
    repeat (4) go(cmd(OP_NEXT, 10'd0));
    go(cmd(OP_PEEK, 10'd0));
    go(cmd(OP_PREV, 10'd0));
    go(cmd(OP_REMOVE, 10'd20));
    go(cmd(OP_NEXT, 10'd0));
    go(cmd(OP_CLEAR, 10'd0));
    go(cmd(OP_ADD, 10'd0));
    go(cmd(OP_NEXT, 10'd0));
    go(cmd(OP_NEXT, 10'd0));
    go(cmd(OP_PEEK, 10'd0));
    go(cmd(OP_ADD, 10'd0));
    go(cmd(OP_NEXT, 10'd0));
    go(cmd(OP_NEXT, 10'd0));
    go(cmd(OP_PEEK, 10'd0));
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: mode_pick = MODE_SHUF;
        1: mode_pick = MODE_LOOP;
        2: mode_pick = MODE_UNUSED;
        3: mode_pick = MODE_SEQ;
        default: mode_pick = 2'($urandom_range(0, 3));
      endcase
      cfg_write(CFG_PLAY_MODE, {62'd0, mode_pick});
      if (p == 0) cfg_write(CFG_SHUFFLE_SEED, '1);
      else if (p == 1 || $urandom_range(0, 1) == 1)
        cfg_write(CFG_SHUFFLE_SEED, {$urandom, $urandom});
      idle_on = (p % 4 != 3);
      repeat (PHASE_ITEMS) go(random_item());
      settle();
    end

    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== playlist_cursor_sequencer.f =====
sv/pcs_pkg.sv
sv/pcs_modu.sv
sv/pcs_dp.sv
sv/pcs_ctrl.sv
sv/playlist_cursor_sequencer.sv
verif/testbench.sv
